[hw/rtl/rpn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rpn_pkg;

  localparam int WordW = 32;

  // input word kinds
  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_ADD  = 2'd1;
  localparam logic [1:0] KIND_MUL  = 2'd2;
  localparam logic [1:0] KIND_SHOW = 2'd3;

  // result status codes
  localparam logic [1:0] ST_SHOWN = 2'd0;
  localparam logic [1:0] ST_UNDER = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;

  localparam logic signed [WordW-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WordW-1:0] Q_MIN = 32'sh8000_0000;

  // classified command, as handed from the front end to the execute unit
  typedef enum logic [2:0] {
    OP_PUSH,
    OP_ADD,
    OP_MUL,
    OP_SHOW,
    OP_UNDER,
    OP_OVER
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic signed [WordW-1:0] value;
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/rpn_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpn_front
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_kind,
  input  wire logic signed [WordW-1:0] in_operand,
  output logic                         cmd_valid,
  input  wire logic                    cmd_ready,
  output cmd_t                         cmd
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  // occupancy depends on the kinds alone, so it is tracked here ahead of execution
  logic [CW-1:0] count_r, count_nxt;
  logic          accept;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd.value = in_operand;
    cmd.op    = OP_SHOW;
    count_nxt = count_r;
    unique case (in_kind)
      KIND_PUSH: begin
        if (count_r == CW'(STACK_DEPTH)) begin
          cmd.op = OP_OVER;
        end else begin
          cmd.op    = OP_PUSH;
          count_nxt = count_r + CW'(1);
        end
      end
      KIND_ADD, KIND_MUL: begin
        if (count_r < CW'(2)) begin
          cmd.op = OP_UNDER;
        end else begin
          cmd.op    = (in_kind == KIND_ADD) ? OP_ADD : OP_MUL;
          count_nxt = count_r - CW'(1);
        end
      end
      KIND_SHOW: begin
        cmd.op = (count_r == '0) ? OP_UNDER : OP_SHOW;
      end
      default: cmd.op = OP_SHOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rpn_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpn_queue
  import rpn_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  wire cmd_t wr_cmd,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cmd_t      rd_cmd
);

  // two-entry FIFO
  cmd_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       push, pop;

  assign wr_ready = (fill_r != 2'd2);
  assign rd_valid = (fill_r != 2'd0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rpn_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module rpn_back
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cmd_valid,
  output logic                         cmd_ready,
  input  wire cmd_t                    cmd,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_status,
  output logic signed [WordW-1:0]      out_shown
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MUL
  } state_t;

  // top entry lives in top_r; entries below it sit in the memory
  logic signed [WordW-1:0] mem [STACK_DEPTH];
  logic signed [WordW-1:0] rd_data_r;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic                    wr_en;

  state_t                    state_r, state_nxt;
  logic [CW-1:0]             sp_r, sp_nxt;
  logic signed [WordW-1:0]   top_r, top_nxt;
  logic                      is_mul_r, is_mul_nxt;
  logic signed [2*WordW-1:0] prod_r, prod_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic signed [WordW-1:0]   out_shown_r, out_shown_nxt;

  logic                      slot_free;
  logic signed [WordW:0]     sum;
  logic signed [2*WordW-1:0] rnd;
  logic signed [WordW-1:0]   sum_sat, mul_sat;

  assign rd_addr = AW'(sp_r - CW'(2));
  assign wr_addr = AW'(sp_r - CW'(1));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= top_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign slot_free = !out_valid_r || out_ready;
  assign cmd_ready = (state_r == S_IDLE) && slot_free;

  // saturating add, left operand is the deeper entry
  assign sum     = {rd_data_r[WordW-1], rd_data_r} + {top_r[WordW-1], top_r};
  assign sum_sat = (sum[WordW] != sum[WordW-1]) ? (sum[WordW] ? Q_MIN : Q_MAX)
                                                 : sum[WordW-1:0];

  // round half up, drop 16 fraction bits, clamp
  assign rnd     = prod_r + 64'sd32768;
  assign mul_sat = ((&rnd[63:47]) || !(|rnd[63:47])) ? rnd[47:16]
                                                     : (rnd[63] ? Q_MIN : Q_MAX);

  always_comb begin
    state_nxt      = state_r;
    sp_nxt         = sp_r;
    top_nxt        = top_r;
    is_mul_nxt     = is_mul_r;
    prod_nxt       = prod_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_shown_nxt  = out_shown_r;
    wr_en          = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          unique case (cmd.op)
            OP_PUSH: begin
              wr_en   = (sp_r != '0);
              top_nxt = cmd.value;
              sp_nxt  = sp_r + CW'(1);
            end
            OP_ADD, OP_MUL: begin
              is_mul_nxt = (cmd.op == OP_MUL);
              state_nxt  = S_READ;
            end
            OP_SHOW: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_SHOWN;
              out_shown_nxt  = top_r;
            end
            OP_UNDER: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_UNDER;
              out_shown_nxt  = '0;
            end
            OP_OVER: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_OVER;
              out_shown_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (is_mul_r) begin
          prod_nxt  = rd_data_r * top_r;
          state_nxt = S_MUL;
        end else begin
          top_nxt   = sum_sat;
          sp_nxt    = sp_r - CW'(1);
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        top_nxt   = mul_sat;
        sp_nxt    = sp_r - CW'(1);
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r        <= top_nxt;
    is_mul_r     <= is_mul_nxt;
    prod_r       <= prod_nxt;
    out_status_r <= out_status_nxt;
    out_shown_r  <= out_shown_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_shown  = out_shown_r;

endmodule

`default_nettype wire

[hw/rtl/rpn_stack_calculator.sv]
// RPN stack calculator, signed Q16.16 operands on a bounded stack.
// Input channel (in_valid/in_ready): one word per command, in_kind selects
// push in_operand, add, multiply or show top. Output channel
// (out_valid/out_ready): status and shown value, only for show and for
// underflow or overflow errors; successful push/add/multiply give no word.
// A front end tracks stack occupancy and classifies each command, then a
// two-entry queue feeds the execute unit that owns the stack memory.
// In the execute unit, push, show and errors are done in the idle state;
// add first reads the second entry from the stack memory; multiply reads
// memory, registers the product, then rounds and clamps. With the queue
// empty, a show passes the queue register, then the out_valid register.
// Reset (rst_n, synchronous) empties the stack and the queue; stack memory
// is not cleared, since only written entries are ever used in a result.
// When the receiver stalls, the result is held in the output register and
// the execute unit takes no further command until it is taken; the queue
// then fills and the input stalls.
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_calculator
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              in_kind,
  input  wire logic signed [WordW-1:0] in_operand,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_status,
  output logic signed [WordW-1:0]      out_shown
);

  logic fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t fq_cmd, qb_cmd;

  rpn_front #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .in_operand(in_operand),
    .cmd_valid (fq_valid),
    .cmd_ready (fq_ready),
    .cmd       (fq_cmd)
  );

  rpn_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_valid(fq_valid),
    .wr_ready(fq_ready),
    .wr_cmd  (fq_cmd),
    .rd_valid(qb_valid),
    .rd_ready(qb_ready),
    .rd_cmd  (qb_cmd)
  );

  rpn_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (qb_valid),
    .cmd_ready (qb_ready),
    .cmd       (qb_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_shown (out_shown)
  );

endmodule

`default_nettype wire
